FILE: rtl/sit_pkg.sv
`default_nettype none

package sit_pkg;

    // Default coordinate width
    localparam int COORD_WIDTH_DEF = 16;

    // Configuration port
    localparam int CFG_INDEX_WIDTH = 3;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_WALL_AX = CFG_INDEX_WIDTH'(0);
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_WALL_AY = CFG_INDEX_WIDTH'(1);
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_WALL_BX = CFG_INDEX_WIDTH'(2);
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_WALL_BY = CFG_INDEX_WIDTH'(3);

    // Result channel: one flag, padded to a byte
    localparam int OUT_TDATA_WIDTH = 8;

    // Coordinate differences (P1/P2 = move, P3/P4 = wall)
    localparam int D_X21 = 0;
    localparam int D_Y21 = 1;
    localparam int D_X31 = 2;
    localparam int D_Y31 = 3;
    localparam int D_X41 = 4;
    localparam int D_Y41 = 5;
    localparam int D_X43 = 6;
    localparam int D_Y43 = 7;
    localparam int D_X13 = 8;
    localparam int D_Y13 = 9;
    localparam int D_X23 = 10;
    localparam int D_Y23 = 11;
    localparam int DIFF_COUNT = 12;

    // Two products per orientation
    localparam int ORIENT_COUNT = 4;
    localparam int PROD_COUNT   = 2 * ORIENT_COUNT;

    // Endpoint-on-segment range checks
    typedef struct packed {
        logic p3_on_move;
        logic p4_on_move;
        logic p1_on_wall;
        logic p2_on_wall;
    } between_t;

    // Orientation signs, bit i for orientation a(i+1)
    typedef struct packed {
        logic [ORIENT_COUNT-1:0] zero;
        logic [ORIENT_COUNT-1:0] pos;
    } orient_t;

endpackage

`default_nettype wire

FILE: rtl/sit_front.sv
`default_nettype none

module sit_front #(
    parameter int W = sit_pkg::COORD_WIDTH_DEF
) (
    input  wire                     aclk,
    input  wire                     aresetn,
    input  wire                     in_valid,
    output logic                    in_ready,
    input  wire logic signed [W-1:0] x1,
    input  wire logic signed [W-1:0] y1,
    input  wire logic signed [W-1:0] x2,
    input  wire logic signed [W-1:0] y2,
    input  wire logic signed [W-1:0] x3,
    input  wire logic signed [W-1:0] y3,
    input  wire logic signed [W-1:0] x4,
    input  wire logic signed [W-1:0] y4,
    output logic                    out_valid,
    input  wire                     out_ready,
    output logic signed [W:0]       diff [sit_pkg::DIFF_COUNT],
    output sit_pkg::between_t       flags
);

    logic                    valid_reg;
    logic signed [W:0]       diff_reg  [sit_pkg::DIFF_COUNT];
    logic signed [W:0]       diff_next [sit_pkg::DIFF_COUNT];
    sit_pkg::between_t       flags_reg;
    sit_pkg::between_t       flags_next;

    function automatic logic signed [W:0] sub(input logic signed [W-1:0] a,
                                              input logic signed [W-1:0] b);
        return $signed({a[W-1], a}) - $signed({b[W-1], b});
    endfunction

    function automatic logic in_range(input logic signed [W-1:0] a,
                                      input logic signed [W-1:0] b,
                                      input logic signed [W-1:0] c);
        return (a <= c && c <= b) || (a >= c && c >= b);
    endfunction

    // Point C within segment AB: x range unless the segment is vertical
    function automatic logic between(input logic signed [W-1:0] ax,
                                     input logic signed [W-1:0] ay,
                                     input logic signed [W-1:0] bx,
                                     input logic signed [W-1:0] by,
                                     input logic signed [W-1:0] cx,
                                     input logic signed [W-1:0] cy);
        return (ax != bx) ? in_range(ax, bx, cx) : in_range(ay, by, cy);
    endfunction

    // Form the twelve differences the orientation products need
    always_comb begin
        diff_next[sit_pkg::D_X21] = sub(x2, x1);
        diff_next[sit_pkg::D_Y21] = sub(y2, y1);
        diff_next[sit_pkg::D_X31] = sub(x3, x1);
        diff_next[sit_pkg::D_Y31] = sub(y3, y1);
        diff_next[sit_pkg::D_X41] = sub(x4, x1);
        diff_next[sit_pkg::D_Y41] = sub(y4, y1);
        diff_next[sit_pkg::D_X43] = sub(x4, x3);
        diff_next[sit_pkg::D_Y43] = sub(y4, y3);
        diff_next[sit_pkg::D_X13] = sub(x1, x3);
        diff_next[sit_pkg::D_Y13] = sub(y1, y3);
        diff_next[sit_pkg::D_X23] = sub(x2, x3);
        diff_next[sit_pkg::D_Y23] = sub(y2, y3);
    end

    // Range checks for the collinear and touching cases
    always_comb begin
        flags_next.p3_on_move = between(x1, y1, x2, y2, x3, y3);
        flags_next.p4_on_move = between(x1, y1, x2, y2, x4, y4);
        flags_next.p1_on_wall = between(x3, y3, x4, y4, x1, y1);
        flags_next.p2_on_wall = between(x3, y3, x4, y4, x2, y2);
    end

    assign in_ready = !valid_reg || out_ready;

    // Advance the stage when the next one has room
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            diff_reg  <= diff_next;
            flags_reg <= flags_next;
        end
    end

    assign out_valid = valid_reg;
    assign diff      = diff_reg;
    assign flags     = flags_reg;

endmodule

`default_nettype wire

FILE: rtl/sit_orient.sv
`default_nettype none

module sit_orient #(
    parameter int W = sit_pkg::COORD_WIDTH_DEF
) (
    input  wire                     aclk,
    input  wire                     aresetn,
    input  wire                     in_valid,
    output logic                    in_ready,
    input  wire logic signed [W:0]  diff [sit_pkg::DIFF_COUNT],
    input  wire sit_pkg::between_t  flags_in,
    output logic                    out_valid,
    input  wire                     out_ready,
    output sit_pkg::orient_t        orient,
    output sit_pkg::between_t       flags_out
);

    localparam int PW = 2 * W + 2;

    // Operand pairs: product 2i is p, 2i+1 is q of orientation i
    localparam int MulA [sit_pkg::PROD_COUNT] = '{
        sit_pkg::D_X21, sit_pkg::D_X31,
        sit_pkg::D_X21, sit_pkg::D_X41,
        sit_pkg::D_X43, sit_pkg::D_X13,
        sit_pkg::D_X43, sit_pkg::D_X23
    };
    localparam int MulB [sit_pkg::PROD_COUNT] = '{
        sit_pkg::D_Y31, sit_pkg::D_Y21,
        sit_pkg::D_Y41, sit_pkg::D_Y21,
        sit_pkg::D_Y13, sit_pkg::D_Y43,
        sit_pkg::D_Y23, sit_pkg::D_Y43
    };

    logic                    prod_valid_reg;
    logic                    prod_ready;
    logic signed [PW-1:0]    prod_reg  [sit_pkg::PROD_COUNT];
    logic signed [PW-1:0]    prod_next [sit_pkg::PROD_COUNT];
    sit_pkg::between_t       prod_flags_reg;

    logic                    sign_valid_reg;
    logic                    sign_ready;
    sit_pkg::orient_t        orient_reg;
    sit_pkg::orient_t        orient_next;
    sit_pkg::between_t       sign_flags_reg;

    assign sign_ready = !sign_valid_reg || out_ready;
    assign prod_ready = !prod_valid_reg || sign_ready;
    assign in_ready   = prod_ready;

    // Eight independent exact products
    always_comb begin
        for (int k = 0; k < sit_pkg::PROD_COUNT; k++) begin
            prod_next[k] = PW'(diff[MulA[k]] * diff[MulB[k]]);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prod_valid_reg <= 1'b0;
        end else if (prod_ready) begin
            prod_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (prod_ready && in_valid) begin
            prod_reg       <= prod_next;
            prod_flags_reg <= flags_in;
        end
    end

    // Compare the two products of each orientation
    always_comb begin
        for (int i = 0; i < sit_pkg::ORIENT_COUNT; i++) begin
            orient_next.zero[i] = (prod_reg[2*i] == prod_reg[2*i+1]);
            orient_next.pos[i]  = (prod_reg[2*i] >  prod_reg[2*i+1]);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sign_valid_reg <= 1'b0;
        end else if (sign_ready) begin
            sign_valid_reg <= prod_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (sign_ready && prod_valid_reg) begin
            orient_reg     <= orient_next;
            sign_flags_reg <= prod_flags_reg;
        end
    end

    assign out_valid = sign_valid_reg;
    assign orient    = orient_reg;
    assign flags_out = sign_flags_reg;

endmodule

`default_nettype wire

FILE: rtl/sit_decide.sv
`default_nettype none

module sit_decide (
    input  wire                     aclk,
    input  wire                     aresetn,
    input  wire                     in_valid,
    output logic                    in_ready,
    input  wire sit_pkg::orient_t   orient,
    input  wire sit_pkg::between_t  flags,
    output logic                    out_valid,
    input  wire                     out_ready,
    output logic                    blocked
);

    logic valid_reg;
    logic blocked_reg;
    logic blocked_next;

    // Settle collinear and touching cases in fixed order, else straddle test
    always_comb begin
        if (orient.zero[0]) begin
            blocked_next = flags.p3_on_move ||
                           (orient.zero[1] && (flags.p1_on_wall || flags.p2_on_wall));
        end else if (orient.zero[1]) begin
            blocked_next = flags.p4_on_move;
        end else if (orient.zero[2]) begin
            blocked_next = flags.p1_on_wall ||
                           (orient.zero[3] && (flags.p3_on_move || flags.p4_on_move));
        end else if (orient.zero[3]) begin
            blocked_next = flags.p2_on_wall;
        end else begin
            blocked_next = (orient.pos[0] ^ orient.pos[1]) &&
                           (orient.pos[2] ^ orient.pos[3]);
        end
    end

    assign in_ready = !valid_reg || out_ready;

    // Hold the result until the receiver takes it
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            blocked_reg <= blocked_next;
        end
    end

    assign out_valid = valid_reg;
    assign blocked   = blocked_reg;

endmodule

`default_nettype wire

FILE: rtl/segment_intersection_test.sv
// Segment intersection test: decides whether a move segment touches or
// crosses a wall segment held in four configuration registers.
//
// Input channel (s_): one move per item, start and end point.
// Result channel (m_): one item per move, bit 0 set when the move is blocked.
// Configuration channel (cfg_): index 0..3 writes wall_ax, wall_ay, wall_bx,
// wall_by; other indexes are ignored. cfg_ready is always high. Write only
// while no move is in flight.
//
// Four register stages: difference and range checks, exact products, product
// compare, decision. An accepted item is registered in each in turn, and
// m_tvalid is the decision stage's valid bit. One item is accepted every
// cycle unless stalled; throughput is set by the eight parallel product
// multipliers. Each stage advances when the next has room, so a stalled
// receiver fills empty stages first and s_tready drops only when all four
// are full. Reset clears all valid bits and the wall registers to zero.
`default_nettype none

module segment_intersection_test #(
    parameter int COORD_WIDTH = sit_pkg::COORD_WIDTH_DEF,
    localparam int S_TDATA_WIDTH = ((4 * COORD_WIDTH + 7) / 8) * 8
) (
    input  wire                                   aclk,
    input  wire                                   aresetn,
    input  wire                                   s_tvalid,
    output logic                                  s_tready,
    // start_x, start_y, end_x, end_y from bit 0 up, zero padded
    input  wire [S_TDATA_WIDTH-1:0]               s_tdata,
    output logic                                  m_tvalid,
    input  wire                                   m_tready,
    // blocked in bit 0, zero padded
    output logic [sit_pkg::OUT_TDATA_WIDTH-1:0]   m_tdata,
    input  wire                                   cfg_valid,
    output logic                                  cfg_ready,
    input  wire [sit_pkg::CFG_INDEX_WIDTH-1:0]    cfg_index,
    input  wire [COORD_WIDTH-1:0]                 cfg_data
);

    localparam int W = COORD_WIDTH;

    logic signed [W-1:0]   wall_ax_reg;
    logic signed [W-1:0]   wall_ay_reg;
    logic signed [W-1:0]   wall_bx_reg;
    logic signed [W-1:0]   wall_by_reg;

    logic signed [W-1:0]   start_x;
    logic signed [W-1:0]   start_y;
    logic signed [W-1:0]   end_x;
    logic signed [W-1:0]   end_y;

    logic                  front_valid;
    logic                  front_ready;
    logic signed [W:0]     front_diff [sit_pkg::DIFF_COUNT];
    sit_pkg::between_t     front_flags;

    logic                  orient_valid;
    logic                  orient_ready;
    sit_pkg::orient_t      orient_sign;
    sit_pkg::between_t     orient_flags;

    logic                  blocked;

    // Configuration writes
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wall_ax_reg <= '0;
            wall_ay_reg <= '0;
            wall_bx_reg <= '0;
            wall_by_reg <= '0;
        end else if (cfg_valid) begin
            case (cfg_index)
                sit_pkg::REG_WALL_AX: wall_ax_reg <= cfg_data;
                sit_pkg::REG_WALL_AY: wall_ay_reg <= cfg_data;
                sit_pkg::REG_WALL_BX: wall_bx_reg <= cfg_data;
                sit_pkg::REG_WALL_BY: wall_by_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Unpack the move
    assign start_x = s_tdata[W-1:0];
    assign start_y = s_tdata[2*W-1:W];
    assign end_x   = s_tdata[3*W-1:2*W];
    assign end_y   = s_tdata[4*W-1:3*W];

    sit_front #(.W(W)) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .x1        (start_x),
        .y1        (start_y),
        .x2        (end_x),
        .y2        (end_y),
        .x3        (wall_ax_reg),
        .y3        (wall_ay_reg),
        .x4        (wall_bx_reg),
        .y4        (wall_by_reg),
        .out_valid (front_valid),
        .out_ready (front_ready),
        .diff      (front_diff),
        .flags     (front_flags)
    );

    sit_orient #(.W(W)) u_orient (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (front_valid),
        .in_ready  (front_ready),
        .diff      (front_diff),
        .flags_in  (front_flags),
        .out_valid (orient_valid),
        .out_ready (orient_ready),
        .orient    (orient_sign),
        .flags_out (orient_flags)
    );

    sit_decide u_decide (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (orient_valid),
        .in_ready  (orient_ready),
        .orient    (orient_sign),
        .flags     (orient_flags),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .blocked   (blocked)
    );

    assign m_tdata = {(sit_pkg::OUT_TDATA_WIDTH - 1)'(0), blocked};

    // Input side stalls only when the output is full and held
    a_stall_from_output: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> (m_tvalid && !m_tready))
        else $error("input stalled without a held result");

    // An empty output stage always leaves room at the input
    a_ready_when_drained: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input not ready while output stage is empty");

    // Wall registers change only through a configuration write
    a_wall_by_write: assert property (@(posedge aclk) disable iff (!aresetn)
        ($past(aresetn) &&
         !$stable({wall_ax_reg, wall_ay_reg, wall_bx_reg, wall_by_reg}))
        |-> $past(cfg_valid))
        else $error("wall changed without a configuration write");

endmodule

`default_nettype wire

FILE: bench/move_hit_checker.sv
`timescale 1ns / 100ps

module move_hit_checker #(
    parameter int W       = sit_pkg::COORD_WIDTH_DEF,
    parameter int TDATA_W = ((4 * W + 7) / 8) * 8
) (
    input  wire                                  aclk,
    input  wire                                  aresetn,
    input  wire                                  s_tvalid,
    input  wire                                  s_tready,
    // start_x, start_y, end_x, end_y from bit 0 up, zero padded
    input  wire [TDATA_W-1:0]                    s_tdata,
    input  wire                                  m_tvalid,
    input  wire                                  m_tready,
    // blocked in bit 0, zero padded
    input  wire [sit_pkg::OUT_TDATA_WIDTH-1:0]   m_tdata,
    input  wire                                  cfg_valid,
    input  wire                                  cfg_ready,
    input  wire [sit_pkg::CFG_INDEX_WIDTH-1:0]   cfg_index,
    input  wire [W-1:0]                          cfg_data,
    output int                                   mismatches,
    output int                                   pending,
    output int                                   results_seen,
    output int                                   hits_seen
);

    typedef logic signed [W-1:0]     coord_t;
    typedef logic signed [W:0]       diff_t;
    typedef logic signed [2*W+2:0]   prod_t;
    typedef enum logic [1:0] {SIDE_NEG, SIDE_ZERO, SIDE_POS} side_t;
    typedef struct packed {
        coord_t ey;
        coord_t ex;
        coord_t sy;
        coord_t sx;
    } move_t;
    typedef struct packed {
        move_t mv;
        logic  hit;
    } hit_entry_t;

    coord_t     wall_ax, wall_ay, wall_bx, wall_by;
    hit_entry_t expected_hits[$];
    int         fail_total   = 0;
    int         result_total = 0;
    int         hit_total    = 0;

    // Side of point C relative to line A->B, by exact product comparison
    function automatic side_t side_of(input coord_t ax, ay, bx, by, cx, cy);
        diff_t dx_ab, dy_ab, dx_ac, dy_ac;
        prod_t p, q;
        dx_ab = diff_t'(bx) - diff_t'(ax);
        dy_ab = diff_t'(by) - diff_t'(ay);
        dx_ac = diff_t'(cx) - diff_t'(ax);
        dy_ac = diff_t'(cy) - diff_t'(ay);
        p = prod_t'(dx_ab) * prod_t'(dy_ac);
        q = prod_t'(dx_ac) * prod_t'(dy_ab);
        if (p > q) return SIDE_POS;
        if (p < q) return SIDE_NEG;
        return SIDE_ZERO;
    endfunction

    // C within the closed range of A..B, on x unless A and B share x
    function automatic logic in_span(input coord_t ax, ay, bx, by, cx, cy);
        if (ax != bx)
            return (ax <= cx && cx <= bx) || (ax >= cx && cx >= bx);
        return (ay <= cy && cy <= by) || (ay >= cy && cy >= by);
    endfunction

    // Does the move touch or cross the current wall
    function automatic logic move_hits_wall(input move_t mv);
        coord_t x1, y1, x2, y2, x3, y3, x4, y4;
        side_t a1, a2, a3, a4;
        x1 = mv.sx; y1 = mv.sy; x2 = mv.ex; y2 = mv.ey;
        x3 = wall_ax; y3 = wall_ay; x4 = wall_bx; y4 = wall_by;
        a1 = side_of(x1, y1, x2, y2, x3, y3);
        a2 = side_of(x1, y1, x2, y2, x4, y4);
        a3 = side_of(x3, y3, x4, y4, x1, y1);
        a4 = side_of(x3, y3, x4, y4, x2, y2);
        if (a1 == SIDE_ZERO) begin
            if (in_span(x1, y1, x2, y2, x3, y3)) return 1'b1;
            if (a2 == SIDE_ZERO)
                return in_span(x3, y3, x4, y4, x1, y1) || in_span(x3, y3, x4, y4, x2, y2);
            return 1'b0;
        end
        if (a2 == SIDE_ZERO) return in_span(x1, y1, x2, y2, x4, y4);
        if (a3 == SIDE_ZERO) begin
            if (in_span(x3, y3, x4, y4, x1, y1)) return 1'b1;
            if (a4 == SIDE_ZERO)
                return in_span(x1, y1, x2, y2, x3, y3) || in_span(x1, y1, x2, y2, x4, y4);
            return 1'b0;
        end
        if (a4 == SIDE_ZERO) return in_span(x3, y3, x4, y4, x2, y2);
        return ((a1 == SIDE_POS) != (a2 == SIDE_POS)) && ((a3 == SIDE_POS) != (a4 == SIDE_POS));
    endfunction

    // Track wall writes, predict each accepted move, compare each result item
    always @(posedge aclk) begin
        move_t                                  mv;
        hit_entry_t                             head;
        logic [sit_pkg::OUT_TDATA_WIDTH-1:0]    want;
        if (!aresetn) begin
            wall_ax = '0;
            wall_ay = '0;
            wall_bx = '0;
            wall_by = '0;
            expected_hits.delete();
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    sit_pkg::REG_WALL_AX: wall_ax = cfg_data;
                    sit_pkg::REG_WALL_AY: wall_ay = cfg_data;
                    sit_pkg::REG_WALL_BX: wall_bx = cfg_data;
                    sit_pkg::REG_WALL_BY: wall_by = cfg_data;
                    default: ;
                endcase
            end
            // Pop before push so a result never matches a move taken this cycle
            if (m_tvalid && m_tready) begin
                result_total++;
                if (m_tdata[0]) hit_total++;
                if (expected_hits.size() == 0) begin
                    fail_total++;
                    if (fail_total <= 10)
                        $display("ERROR %0t: result item with no move outstanding, m_tdata=%0h",
                                 $time, m_tdata);
                end else begin
                    head = expected_hits.pop_front();
                    want = (sit_pkg::OUT_TDATA_WIDTH)'(head.hit);
                    if (m_tdata !== want) begin
                        fail_total++;
                        if (fail_total <= 10) begin
                            $display("ERROR %0t: move (%0d,%0d)->(%0d,%0d) wall (%0d,%0d)-(%0d,%0d)",
                                     $time, head.mv.sx, head.mv.sy, head.mv.ex, head.mv.ey,
                                     wall_ax, wall_ay, wall_bx, wall_by);
                            $display("    blocked expected %0h, got m_tdata %0h", want, m_tdata);
                        end
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                mv = move_t'(s_tdata[4*W-1:0]);
                expected_hits.push_back({mv, move_hits_wall(mv)});
            end
        end
        mismatches   <= fail_total;
        pending      <= expected_hits.size();
        results_seen <= result_total;
        hits_seen    <= hit_total;
    end

endmodule

FILE: bench/tb_top.sv
`timescale 1ns / 100ps

module tb_top;

    localparam int W               = sit_pkg::COORD_WIDTH_DEF;
    localparam int S_W             = ((4 * W + 7) / 8) * 8;
    localparam int RANDOM_PHASES   = 10;
    localparam int ITEMS_PER_PHASE = 195;
    localparam int BURST_ITEMS     = 150;
    localparam int HOLD_CYCLES     = 80;
    localparam int IDLE_LIMIT      = 2000;
    localparam int TAIL_CYCLES     = 8;

    typedef logic signed [W-1:0] coord_t;
    typedef enum int {WALL_SPREAD, WALL_SHORT, WALL_AXIS, WALL_POINT, WALL_CORNER} wall_kind_t;

    localparam coord_t COORD_MIN = {1'b1, {(W-1){1'b0}}};
    localparam coord_t COORD_MAX = ~COORD_MIN;

    logic                                 aclk      = 1'b0;
    logic                                 aresetn   = 1'b0;
    logic                                 s_tvalid  = 1'b0;
    logic [S_W-1:0]                       s_tdata   = '0;
    logic                                 m_tready  = 1'b0;
    logic                                 cfg_valid = 1'b0;
    logic [sit_pkg::CFG_INDEX_WIDTH-1:0]  cfg_index = '0;
    logic [W-1:0]                         cfg_data  = '0;
    wire                                  s_tready;
    wire                                  m_tvalid;
    wire [sit_pkg::OUT_TDATA_WIDTH-1:0]   m_tdata;
    wire                                  cfg_ready;

    int     mismatches, pending, results_seen, hits_seen;
    coord_t cur_ax = '0, cur_ay = '0, cur_bx = '0, cur_by = '0;
    bit     sender_gaps_on = 1'b1;
    bit     hold_off_req   = 1'b0;
    // the reset value of the wall counts as the first setting
    int     wall_settings  = 1;

    always #5 aclk = ~aclk;

    segment_intersection_test #(.COORD_WIDTH(W)) dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    move_hit_checker #(.W(W), .TDATA_W(S_W)) chk (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .mismatches   (mismatches),
        .pending      (pending),
        .results_seen (results_seen),
        .hits_seen    (hits_seen)
    );

    // Mostly short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic coord_t near(input coord_t c);
        return coord_t'(int'(c) + int'($urandom_range(0, 32)) - 16);
    endfunction

    function automatic coord_t corner_value();
        case ($urandom_range(0, 3))
            0: return COORD_MIN;
            1: return COORD_MAX;
            2: return '0;
            default: return '1;
        endcase
    endfunction

    // Point on the wall's line, at a whole step of its reduced direction
    function automatic void along_wall(output coord_t px, output coord_t py);
        int dx, dy, a, b, t, k;
        dx = int'(cur_bx) - int'(cur_ax);
        dy = int'(cur_by) - int'(cur_ay);
        a  = (dx < 0) ? -dx : dx;
        b  = (dy < 0) ? -dy : dy;
        while (b != 0) begin
            t = a % b;
            a = b;
            b = t;
        end
        if (a == 0) begin
            px = cur_ax;
            py = cur_ay;
            return;
        end
        k  = int'($urandom_range(0, a + 6)) - 3;
        px = coord_t'(int'(cur_ax) + k * (dx / a));
        py = coord_t'(int'(cur_ay) + k * (dy / a));
    endfunction

    // Offer one move and hold it until accepted
    task automatic send_move(input coord_t sx, sy, ex, ey);
        int gap;
        gap = sender_gaps_on ? pick_gap() : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= S_W'({ey, ex, sy, sx});
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic cfg_write(input logic [sit_pkg::CFG_INDEX_WIDTH-1:0] idx,
                             input coord_t value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
    endtask

    // Load a new wall; a stray write to an unused index goes first when asked
    task automatic set_wall(input coord_t ax, ay, bx, by, input bit stray);
        if (stray)
            cfg_write(sit_pkg::REG_WALL_BY +
                      (sit_pkg::CFG_INDEX_WIDTH)'(1 + $urandom_range(0, 3)),
                      coord_t'($urandom));
        cfg_write(sit_pkg::REG_WALL_AX, ax);
        cfg_write(sit_pkg::REG_WALL_AY, ay);
        cfg_write(sit_pkg::REG_WALL_BX, bx);
        cfg_write(sit_pkg::REG_WALL_BY, by);
        cfg_valid <= 1'b0;
        cur_ax = ax;
        cur_ay = ay;
        cur_bx = bx;
        cur_by = by;
        wall_settings++;
    endtask

    // Drop valid and wait until every predicted result has come back
    task automatic settle();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (pending != 0);
    endtask

    task automatic random_wall(input wall_kind_t kind);
        coord_t ax, ay, bx, by;
        ax = coord_t'($urandom);
        ay = coord_t'($urandom);
        bx = coord_t'($urandom);
        by = coord_t'($urandom);
        case (kind)
            WALL_SHORT: begin
                bx = coord_t'(int'(ax) + int'($urandom_range(0, 128)) - 64);
                by = coord_t'(int'(ay) + int'($urandom_range(0, 128)) - 64);
            end
            WALL_AXIS: begin
                if ($urandom_range(0, 1)) by = ay;
                else bx = ax;
            end
            WALL_POINT: begin
                bx = ax;
                by = ay;
            end
            WALL_CORNER: begin
                ax = corner_value();
                ay = corner_value();
                bx = corner_value();
                by = corner_value();
            end
            default: ;
        endcase
        set_wall(ax, ay, bx, by, $urandom_range(0, 3) == 0);
    endtask

    // Spread moves, moves near the wall ends, and moves along the wall line
    task automatic random_move();
        int     r;
        coord_t sx, sy, ex, ey;
        r = $urandom_range(0, 99);
        if (r < 25) begin
            sx = coord_t'($urandom);
            sy = coord_t'($urandom);
            ex = coord_t'($urandom);
            ey = coord_t'($urandom);
        end else if (r < 70) begin
            if ($urandom_range(0, 1)) begin
                sx = near(cur_ax);
                sy = near(cur_ay);
            end else begin
                sx = near(cur_bx);
                sy = near(cur_by);
            end
            case ($urandom_range(0, 2))
                0: begin ex = near(cur_ax); ey = near(cur_ay); end
                1: begin ex = near(cur_bx); ey = near(cur_by); end
                default: begin ex = near(sx); ey = near(sy); end
            endcase
        end else begin
            along_wall(sx, sy);
            along_wall(ex, ey);
            if ($urandom_range(0, 3) == 0) begin
                ex = near(ex);
                ey = near(ey);
            end
        end
        if ($urandom_range(0, 19) == 0) begin
            ex = sx;
            ey = sy;
        end
        send_move(sx, sy, ex, ey);
    endtask

    // Receiver: random stalls and ready stretches, one long hold on request
    initial begin : receiver
        int stall, run;
        wait (aresetn);
        @(posedge aclk);
        forever begin
            if (hold_off_req) begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                hold_off_req = 1'b0;
            end
            stall = pick_gap();
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            run = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 12);
            m_tready <= 1'b1;
            repeat (run) @(posedge aclk);
        end
    end

    // End the run when no item moves on any channel for too long
    initial begin : watchdog
        int idle;
        idle = 0;
        while (idle < IDLE_LIMIT) begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
                idle = 0;
            else
                idle++;
        end
        $display("Watchdog: no item moved for %0d cycles", IDLE_LIMIT);
        $display("Test completed with failures");
        $finish;
    end

    initial begin : stimulus
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // Wall left at reset: a point at the origin
        send_move(-5, 0, 5, 0);
        send_move(-5, 1, 5, 1);
        send_move(5, 0, 7, 3);
        send_move(0, 0, 0, 0);
        settle();

        // Diagonal wall: crossing, parallel, collinear, touching, point moves
        set_wall(0, 0, 10, 10, 1'b0);
        send_move(0, 10, 10, 0);
        send_move(0, 1, 10, 11);
        send_move(5, 5, 20, 20);
        send_move(11, 11, 20, 20);
        send_move(-5, -5, 20, 20);
        send_move(10, 10, 20, 0);
        send_move(5, 5, 5, -10);
        send_move(0, 10, 5, 5);
        send_move(3, 3, 3, 3);
        send_move(3, 4, 3, 4);
        settle();

        // Vertical wall spanning the full range
        set_wall(5, COORD_MIN, 5, COORD_MAX, 1'b0);
        send_move(5, 100, 5, 200);
        send_move(COORD_MIN, 0, COORD_MAX, 0);
        send_move(6, COORD_MIN, 6, COORD_MAX);
        settle();

        // Corner to corner wall, largest products; stray index must be ignored
        set_wall(COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX, 1'b1);
        send_move(COORD_MIN, COORD_MAX, COORD_MAX, COORD_MIN);
        send_move(COORD_MAX, COORD_MIN, COORD_MAX, COORD_MIN);
        send_move(COORD_MAX, COORD_MAX - 1, COORD_MIN, COORD_MIN + 1);
        send_move(-1, -1, 0, 0);
        settle();

        // Random phases, each with a fresh wall
        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            random_wall(wall_kind_t'(phase % 5));
            sender_gaps_on = (phase % 3 != 2);
            if (phase == 1) begin
                hold_off_req   = 1'b1;
                sender_gaps_on = 1'b0;
            end
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                if (phase == 1 && n == BURST_ITEMS) sender_gaps_on = 1'b1;
                random_move();
            end
            settle();
        end

        repeat (TAIL_CYCLES) @(posedge aclk);
        $display("Summary: %0d moves checked over %0d wall settings, %0d blocked.",
                 results_seen, wall_settings, hits_seen);
        $display("Covered crossing, collinear, touching, point and extreme walls and moves,");
        $display("with random idles on both channels and one long receiver hold.");
        if (mismatches == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
